[hdl/dsp_pkg.sv]
package dsp_pkg;

  localparam int NumRounds = 80;
  localparam int NumWords  = 8;
  localparam int CfgIdxW   = 3;

  localparam logic [63:0] PadWord  = 64'h8000000000000000;
  localparam logic [63:0] Msg1Bits = 64'd576;
  localparam logic [63:0] Msg2Bits = 64'd512;

  typedef struct packed {
    logic [63:0] trial_nonce;
    logic [63:0] target_limit;
  } in_item_t;

  typedef struct packed {
    logic [63:0] trial_value;
    logic        meets_target;
  } out_item_t;

  typedef logic [15:0][63:0] sched_t;
  typedef logic [7:0][63:0]  hash_t;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] k [0:79];
    k = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    round_k = k[t];
  endfunction

  function automatic hash_t start_h();
    start_h = {64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f,
               64'h510e527fade682d1, 64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
               64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908};
  endfunction

endpackage

[hdl/dsp_round.sv]
// One SHA-512 round plus one message schedule step, registered.
// Schedule window: w[0] is the word used by this round.
module dsp_round (
  input  logic              clk,
  input  logic              rst,
  input  logic [6:0]        rnd,
  input  logic              in_valid,
  input  dsp_pkg::hash_t    in_state,
  input  dsp_pkg::sched_t   in_sched,
  input  dsp_pkg::hash_t    in_hold,
  input  dsp_pkg::in_item_t in_item,
  output logic              out_valid,
  output dsp_pkg::hash_t    out_state,
  output dsp_pkg::sched_t   out_sched,
  output dsp_pkg::hash_t    out_hold,
  output dsp_pkg::in_item_t out_item
);

  logic [63:0] e, a, big1, ch, t1, big0, maj, w15, w2, s0, s1, wn;
  dsp_pkg::hash_t  st_next;
  dsp_pkg::sched_t sc_next;

  always_comb begin
    e    = in_state[4];
    a    = in_state[0];
    big1 = dsp_pkg::rotr(e, 14) ^ dsp_pkg::rotr(e, 18) ^ dsp_pkg::rotr(e, 41);
    ch   = (e & in_state[5]) ^ (~e & in_state[6]);
    t1   = in_state[7] + big1 + ch + dsp_pkg::round_k(rnd) + in_sched[0];
    big0 = dsp_pkg::rotr(a, 28) ^ dsp_pkg::rotr(a, 34) ^ dsp_pkg::rotr(a, 39);
    maj  = (a & in_state[1]) ^ (a & in_state[2]) ^ (in_state[1] & in_state[2]);
    st_next    = {in_state[6:4], in_state[3] + t1, in_state[2:0], t1 + big0 + maj};
    w15  = in_sched[1];
    w2   = in_sched[14];
    s0   = dsp_pkg::rotr(w15, 1) ^ dsp_pkg::rotr(w15, 8) ^ (w15 >> 7);
    s1   = dsp_pkg::rotr(w2, 19) ^ dsp_pkg::rotr(w2, 61) ^ (w2 >> 6);
    wn   = in_sched[0] + s0 + in_sched[9] + s1;
    sc_next = {wn, in_sched[15:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_state <= st_next;
    out_sched <= sc_next;
    out_hold  <= in_hold;
    out_item  <= in_item;
  end

endmodule

[hdl/dsp_hash.sv]
// Fully unrolled SHA-512 compression from the standard IV: 80 round stages
// and one feed-forward stage.
module dsp_hash (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  dsp_pkg::sched_t   in_block,
  input  dsp_pkg::in_item_t in_item,
  output logic              out_valid,
  output dsp_pkg::hash_t    out_digest,
  output dsp_pkg::in_item_t out_item
);

  logic              v  [0:dsp_pkg::NumRounds];
  dsp_pkg::hash_t    st [0:dsp_pkg::NumRounds];
  dsp_pkg::sched_t   sc [0:dsp_pkg::NumRounds];
  dsp_pkg::hash_t    hd [0:dsp_pkg::NumRounds];
  dsp_pkg::in_item_t it [0:dsp_pkg::NumRounds];
  dsp_pkg::hash_t    dig_next;

  assign v[0]  = in_valid;
  assign st[0] = dsp_pkg::start_h();
  assign sc[0] = in_block;
  assign hd[0] = dsp_pkg::start_h();
  assign it[0] = in_item;

  for (genvar r = 0; r < dsp_pkg::NumRounds; r++) begin : g_rnd
    dsp_round u_round (
      .clk(clk), .rst(rst), .rnd(7'(r)),
      .in_valid(v[r]), .in_state(st[r]), .in_sched(sc[r]), .in_hold(hd[r]),
      .in_item(it[r]),
      .out_valid(v[r+1]), .out_state(st[r+1]), .out_sched(sc[r+1]),
      .out_hold(hd[r+1]), .out_item(it[r+1])
    );
  end

  always_comb begin
    for (int i = 0; i < dsp_pkg::NumWords; i++) begin
      dig_next[i] = hd[dsp_pkg::NumRounds][i] + st[dsp_pkg::NumRounds][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v[dsp_pkg::NumRounds];
    end
    out_digest <= dig_next;
    out_item   <= it[dsp_pkg::NumRounds];
  end

endmodule

[hdl/double_sha512_pow_trial_check_top.sv]
// Pipeline: the input register loads on the accepting edge, then two 81-stage
// compressions and one compare/output stage lead to the done strobe.
// Throughput: one item per cycle; busy is always low, start every cycle is fine.
// Reset: synchronous, active high; clears pipeline valid bits and zeroes the
// eight initial hash registers. Results cannot be stalled by the receiver.
module double_sha512_pow_trial_check_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dsp_pkg::in_item_t  in_item,
  output logic               done,
  output dsp_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  // Initial hash words (object digest); the user writes them only while idle (not enforced).
  dsp_pkg::hash_t ih;

  // Input stage: build the first padded block.
  logic              s0_valid;
  dsp_pkg::sched_t   s0_block;
  dsp_pkg::in_item_t s0_item;

  logic              h1_valid, h2_valid;
  dsp_pkg::hash_t    h1_dig, h2_dig;
  dsp_pkg::in_item_t h1_item, h2_item;
  dsp_pkg::sched_t   blk2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ih <= '0;
    end else if (cfg_we && cfg_index < 4'(dsp_pkg::NumWords)) begin
      ih[cfg_index[dsp_pkg::CfgIdxW-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    // word 0 is the nonce, words 1..8 the initial hash, then padding
    s0_block <= {dsp_pkg::Msg1Bits, 320'd0, dsp_pkg::PadWord, ih,
                 in_item.trial_nonce};
    s0_item  <= in_item;
  end

  dsp_hash u_hash1 (
    .clk(clk), .rst(rst), .in_valid(s0_valid), .in_block(s0_block),
    .in_item(s0_item), .out_valid(h1_valid), .out_digest(h1_dig), .out_item(h1_item)
  );

  // Second block: the 64-byte first digest, padded.
  assign blk2 = {dsp_pkg::Msg2Bits, 384'd0, dsp_pkg::PadWord, h1_dig};

  dsp_hash u_hash2 (
    .clk(clk), .rst(rst), .in_valid(h1_valid), .in_block(blk2),
    .in_item(h1_item), .out_valid(h2_valid), .out_digest(h2_dig), .out_item(h2_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= h2_valid;
    end
    out_item.trial_value  <= h2_dig[0];
    out_item.meets_target <= (h2_dig[0] <= h2_item.target_limit);
  end

`ifndef SYNTHESIS
  a_s0: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> s0_valid)
    else $error("input stage lost an item");
  a_h1: assert property (@(posedge clk) disable iff (rst) !s0_valid |-> ##81 !h1_valid)
    else $error("first hash invented an item");
  a_dn: assert property (@(posedge clk) disable iff (rst) h2_valid |=> done)
    else $error("result strobe missing");
`endif

endmodule
